/* hw/rtl/iprt_pkg.sv */
`default_nettype none

package iprt_pkg;

  localparam int ADDR_W     = 32;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int IFC_PORT_W = 8;
  localparam int COST_PORT_W = 16;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam mode_t MODE_LOOKUP_ANY = 2'd0;
  localparam mode_t MODE_LOOKUP_IFC = 2'd1;
  localparam mode_t MODE_UPSERT     = 2'd2;

  localparam status_t ST_FOUND    = 3'd0;
  localparam status_t ST_NO_ROUTE = 3'd1;
  localparam status_t ST_UPDATED  = 3'd2;
  localparam status_t ST_INSERTED = 3'd3;
  localparam status_t ST_FULL     = 3'd4;

endpackage

`default_nettype wire

/* hw/rtl/ipv4_route_table_lookup.sv */
`default_nettype none

// IPv4 route table with longest-prefix-match lookup and route upsert. Each
// transaction is one operation: mode 0 looks up the address on any interface,
// mode 1 only on interface_id, mode 2 updates the route with the same
// destination, mask and interface or inserts it in the lowest free slot.
// Lookup picks the greatest netmask, then the lower cost, then the lower slot.
// Every lookup and upsert scans the whole table through a single-port entry
// memory, one entry per cycle; mode 3 skips the scan and returns no route.
// in_ready is low from accept until the result is registered. The result
// sits in an output register, and the next transaction can be accepted while
// it waits. Entries are never removed; reset clears only the valid bits.
module ipv4_route_table_lookup #(
  parameter int TABLE_ENTRIES  = 16,
  parameter int INTERFACE_BITS = 8,
  parameter int COST_BITS      = 16
) (
  input  wire                                     clk,
  input  wire                                     rst,

  input  wire                                     in_valid,
  output logic                                    in_ready,
  input  wire  [iprt_pkg::MODE_W-1:0]             mode,
  input  wire  [iprt_pkg::ADDR_W-1:0]             address,
  input  wire  [iprt_pkg::ADDR_W-1:0]             mask,
  input  wire  [iprt_pkg::ADDR_W-1:0]             next_hop,
  input  wire  [iprt_pkg::IFC_PORT_W-1:0]         interface_id,
  input  wire  [iprt_pkg::COST_PORT_W-1:0]        cost,

  output logic                                    out_valid,
  input  wire                                     out_ready,
  output logic [iprt_pkg::STATUS_W-1:0]           status,
  output logic [iprt_pkg::ADDR_W-1:0]             route_dest,
  output logic [iprt_pkg::ADDR_W-1:0]             route_mask,
  output logic [iprt_pkg::ADDR_W-1:0]             route_gateway,
  output logic [iprt_pkg::IFC_PORT_W-1:0]         route_interface,
  output logic [iprt_pkg::COST_PORT_W-1:0]        route_cost
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int IFX_W = (INTERFACE_BITS > iprt_pkg::IFC_PORT_W) ?
                         INTERFACE_BITS : iprt_pkg::IFC_PORT_W;
  localparam int CX_W  = (COST_BITS > iprt_pkg::COST_PORT_W) ?
                         COST_BITS : iprt_pkg::COST_PORT_W;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_ENTRIES);

  typedef struct packed {
    logic [iprt_pkg::ADDR_W-1:0] dest;
    logic [iprt_pkg::ADDR_W-1:0] mask;
    logic [iprt_pkg::ADDR_W-1:0] gateway;
    logic [INTERFACE_BITS-1:0]   ifc;
    logic [COST_BITS-1:0]        cost;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;

  // request held for the whole scan
  iprt_pkg::mode_t             req_mode;
  entry_t                      req;

  // entry memory and valid flags
  entry_t                      mem [TABLE_ENTRIES];
  entry_t                      rd_data;
  logic [TABLE_ENTRIES-1:0]    entry_valid;

  logic [CNT_W-1:0]            cnt;
  logic [IDX_W-1:0]            rd_addr;
  logic                        rd_live;
  logic [IDX_W-1:0]            rd_idx;

  logic                        best_found;
  entry_t                      best;
  logic                        match_found;
  logic [IDX_W-1:0]            match_idx;
  logic                        free_found;
  logic [IDX_W-1:0]            free_idx;

  logic                        rd_valid_bit;
  logic                        hit_lookup;
  logic                        better;
  logic                        hit_upsert;

  logic                        fin_go;
  iprt_pkg::status_t           fin_status;
  entry_t                      fin_entry;
  logic                        mem_we;
  logic                        set_valid;
  logic [IDX_W-1:0]            wr_idx;

  logic [IFX_W-1:0]            ifc_in_ext;
  logic [CX_W-1:0]             cost_in_ext;
  logic [IFX_W-1:0]            ifc_out_ext;
  logic [CX_W-1:0]             cost_out_ext;

  assign in_ready    = (state == S_IDLE);
  assign rd_addr     = cnt[IDX_W-1:0];
  assign ifc_in_ext  = IFX_W'(interface_id);
  assign cost_in_ext = CX_W'(cost);
  assign ifc_out_ext  = IFX_W'(fin_entry.ifc);
  assign cost_out_ext = CX_W'(fin_entry.cost);

  // per-entry evaluation on the registered read data
  always_comb begin
    rd_valid_bit = entry_valid[rd_idx];
    hit_lookup   = rd_live && rd_valid_bit &&
                   ((req_mode != iprt_pkg::MODE_LOOKUP_IFC) || (rd_data.ifc == req.ifc)) &&
                   (((req.dest ^ rd_data.dest) & rd_data.mask) == '0);
    better       = !best_found || (rd_data.mask > best.mask) ||
                   ((rd_data.mask == best.mask) && (rd_data.cost < best.cost));
    hit_upsert   = rd_live && rd_valid_bit && (rd_data.dest == req.dest) &&
                   (rd_data.mask == req.mask) && (rd_data.ifc == req.ifc);
  end

  // final result and table write
  always_comb begin
    fin_go     = (state == S_FINISH) && (!out_valid || out_ready);
    fin_status = iprt_pkg::ST_NO_ROUTE;
    fin_entry  = '0;
    mem_we     = 1'b0;
    set_valid  = 1'b0;
    wr_idx     = match_idx;
    unique case (req_mode)
      iprt_pkg::MODE_LOOKUP_ANY, iprt_pkg::MODE_LOOKUP_IFC: begin
        if (best_found) begin
          fin_status = iprt_pkg::ST_FOUND;
          fin_entry  = best;
        end
      end
      iprt_pkg::MODE_UPSERT: begin
        priority if (match_found) begin
          fin_status = iprt_pkg::ST_UPDATED;
          fin_entry  = req;
          mem_we     = fin_go;
        end else if (free_found) begin
          fin_status = iprt_pkg::ST_INSERTED;
          fin_entry  = req;
          mem_we     = fin_go;
          set_valid  = fin_go;
          wr_idx     = free_idx;
        end else begin
          fin_status = iprt_pkg::ST_FULL;
        end
      end
      default: begin
        fin_status = iprt_pkg::ST_NO_ROUTE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= fin_entry;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_valid <= '0;
      out_valid   <= 1'b0;
      rd_live     <= 1'b0;
      cnt         <= '0;
      best_found  <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      if (out_valid && out_ready && !fin_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_mode     <= mode;
            req.dest     <= address;
            req.mask     <= mask;
            req.gateway  <= next_hop;
            req.ifc      <= ifc_in_ext[INTERFACE_BITS-1:0];
            req.cost     <= cost_in_ext[COST_BITS-1:0];
            cnt          <= '0;
            rd_live      <= 1'b0;
            best_found   <= 1'b0;
            match_found  <= 1'b0;
            free_found   <= 1'b0;
            state        <= (mode == iprt_pkg::MODE_LOOKUP_ANY ||
                             mode == iprt_pkg::MODE_LOOKUP_IFC ||
                             mode == iprt_pkg::MODE_UPSERT) ? S_SCAN : S_FINISH;
          end
        end
        S_SCAN: begin
          // each entry is evaluated in the cycle after its read is issued
          if (cnt != LAST_CNT) begin
            cnt     <= cnt + 1'b1;
            rd_live <= 1'b1;
            rd_idx  <= rd_addr;
          end else begin
            rd_live <= 1'b0;
          end
          if (hit_lookup && better) begin
            best_found <= 1'b1;
            best       <= rd_data;
          end
          if (hit_upsert && !match_found) begin
            match_found <= 1'b1;
            match_idx   <= rd_idx;
          end
          if (rd_live && !rd_valid_bit && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= rd_idx;
          end
          if (cnt == LAST_CNT && !rd_live) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (fin_go) begin
            out_valid       <= 1'b1;
            status          <= fin_status;
            route_dest      <= fin_entry.dest;
            route_mask      <= fin_entry.mask;
            route_gateway   <= fin_entry.gateway;
            route_interface <= ifc_out_ext[iprt_pkg::IFC_PORT_W-1:0];
            route_cost      <= cost_out_ext[iprt_pkg::COST_PORT_W-1:0];
            if (set_valid) begin
              entry_valid[wr_idx] <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // routes are never removed
  a_valid_monotonic: assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) >= $past($countones(entry_valid)))
    else $error("route table lost a valid entry");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == iprt_pkg::ST_FULL) |-> (&entry_valid))
    else $error("table full reported with a free slot");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a transaction while the previous one runs");

  a_no_read_when_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !rd_live)
    else $error("scan read pending while idle");

  a_insert_sets_valid: assert property (@(posedge clk) disable iff (rst)
    set_valid |=> entry_valid[$past(wr_idx)])
    else $error("inserted entry not marked valid");
`endif

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_ENTRIES  = 16;
  localparam int INTERFACE_BITS = 8;
  localparam int COST_BITS      = 16;
  localparam int QUIET_LIMIT    = 2000;
  localparam int RANDOM_OPS     = 630;

  // mode 3 has no name in the package; the block treats it as a no-op
  localparam iprt_pkg::mode_t MODE_RESERVED = 2'd3;

  typedef logic [iprt_pkg::ADDR_W-1:0]      addr_t;
  typedef logic [iprt_pkg::IFC_PORT_W-1:0]  ifc_t;
  typedef logic [iprt_pkg::COST_PORT_W-1:0] cost_t;

  typedef struct {
    iprt_pkg::status_t status;
    addr_t   dest;
    addr_t   mask;
    addr_t   gateway;
    ifc_t    ifc;
    cost_t   cost;
  } route_reply_t;

  class route_table_tracker;
    bit    ent_valid[TABLE_ENTRIES];
    addr_t ent_dest[TABLE_ENTRIES];
    addr_t ent_mask[TABLE_ENTRIES];
    addr_t ent_gateway[TABLE_ENTRIES];
    ifc_t  ent_ifc[TABLE_ENTRIES];
    cost_t ent_cost[TABLE_ENTRIES];
    route_reply_t expected_replies[$];
    int mismatches;

    function route_reply_t slot_reply(iprt_pkg::status_t st, int slot);
      route_reply_t r;
      r.status = st;
      if (slot < 0) begin
        r.dest = '0;
        r.mask = '0;
        r.gateway = '0;
        r.ifc = '0;
        r.cost = '0;
      end else begin
        r.dest = ent_dest[slot];
        r.mask = ent_mask[slot];
        r.gateway = ent_gateway[slot];
        r.ifc = ent_ifc[slot];
        r.cost = ent_cost[slot];
      end
      return r;
    endfunction

    // random valid slot, or -1 when the table is empty
    function int pick_slot();
      int used[$];
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (ent_valid[i]) used.push_back(i);
      if (used.size() == 0) return -1;
      return used[$urandom_range(0, used.size() - 1)];
    endfunction

    function void predict_reply(iprt_pkg::mode_t md, addr_t addr, addr_t msk, addr_t nh,
                                ifc_t ifc, cost_t c);
      int best;
      int slot;
      bit found;
      best = 0;
      slot = -1;
      found = 0;
      case (md)
        iprt_pkg::MODE_LOOKUP_ANY, iprt_pkg::MODE_LOOKUP_IFC: begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!ent_valid[i]) continue;
            if (md == iprt_pkg::MODE_LOOKUP_IFC && ent_ifc[i] != ifc) continue;
            if ((addr & ent_mask[i]) != (ent_dest[i] & ent_mask[i])) continue;
            if (!found || ent_mask[i] > ent_mask[best] ||
                (ent_mask[i] == ent_mask[best] && ent_cost[i] < ent_cost[best])) begin
              best = i;
              found = 1;
            end
          end
          expected_replies.push_back(found ? slot_reply(iprt_pkg::ST_FOUND, best)
                                           : slot_reply(iprt_pkg::ST_NO_ROUTE, -1));
        end
        iprt_pkg::MODE_UPSERT: begin
          for (int i = 0; i < TABLE_ENTRIES && slot < 0; i++)
            if (ent_valid[i] && ent_dest[i] == addr && ent_mask[i] == msk &&
                ent_ifc[i] == ifc) slot = i;
          found = (slot >= 0);
          for (int i = 0; i < TABLE_ENTRIES && slot < 0; i++)
            if (!ent_valid[i]) slot = i;
          if (slot < 0) begin
            expected_replies.push_back(slot_reply(iprt_pkg::ST_FULL, -1));
          end else begin
            ent_valid[slot] = 1'b1;
            ent_dest[slot] = addr;
            ent_mask[slot] = msk;
            ent_gateway[slot] = nh;
            ent_ifc[slot] = ifc;
            ent_cost[slot] = c;
            expected_replies.push_back(
              slot_reply(found ? iprt_pkg::ST_UPDATED : iprt_pkg::ST_INSERTED, slot));
          end
        end
        default: expected_replies.push_back(slot_reply(iprt_pkg::ST_NO_ROUTE, -1));
      endcase
    endfunction

    function void check_reply(route_reply_t got);
      route_reply_t exp_r;
      if (expected_replies.size() == 0) begin
        $error("result with nothing expected: status %0d dest %h", got.status, got.dest);
        mismatches++;
        return;
      end
      exp_r = expected_replies.pop_front();
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, got.status);
        mismatches++;
      end
      if (got.dest !== exp_r.dest) begin
        $error("route_dest: expected %h, got %h", exp_r.dest, got.dest);
        mismatches++;
      end
      if (got.mask !== exp_r.mask) begin
        $error("route_mask: expected %h, got %h", exp_r.mask, got.mask);
        mismatches++;
      end
      if (got.gateway !== exp_r.gateway) begin
        $error("route_gateway: expected %h, got %h", exp_r.gateway, got.gateway);
        mismatches++;
      end
      if (got.ifc !== exp_r.ifc) begin
        $error("route_interface: expected %h, got %h", exp_r.ifc, got.ifc);
        mismatches++;
      end
      if (got.cost !== exp_r.cost) begin
        $error("route_cost: expected %h, got %h", exp_r.cost, got.cost);
        mismatches++;
      end
    endfunction
  endclass

  logic    clk;
  logic    rst = 1'b1;
  logic    in_valid = 1'b0;
  logic    in_ready;
  iprt_pkg::mode_t mode = iprt_pkg::MODE_LOOKUP_ANY;
  addr_t   address = '0;
  addr_t   mask = '0;
  addr_t   next_hop = '0;
  ifc_t    interface_id = '0;
  cost_t   cost = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  iprt_pkg::status_t status;
  addr_t   route_dest;
  addr_t   route_mask;
  addr_t   route_gateway;
  ifc_t    route_interface;
  cost_t   route_cost;

  bit gaps_on = 1'b1;
  int quiet_cycles = 0;
  route_table_tracker routes = new;

  ipv4_route_table_lookup #(
    .TABLE_ENTRIES  (TABLE_ENTRIES),
    .INTERFACE_BITS (INTERFACE_BITS),
    .COST_BITS      (COST_BITS)
  ) DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .mode            (mode),
    .address         (address),
    .mask            (mask),
    .next_hop        (next_hop),
    .interface_id    (interface_id),
    .cost            (cost),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .route_dest      (route_dest),
    .route_mask      (route_mask),
    .route_gateway   (route_gateway),
    .route_interface (route_interface),
    .route_cost      (route_cost)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= gaps_on ? ($urandom_range(0, 99) >= 31) : 1'b1;
  end

  // results are checked before the new transaction is noted, so a result
  // accepted on the same edge can never match its own request
  always @(posedge clk) begin
    route_reply_t got;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got.status = status;
        got.dest = route_dest;
        got.mask = route_mask;
        got.gateway = route_gateway;
        got.ifc = route_interface;
        got.cost = route_cost;
        routes.check_reply(got);
      end
      if (in_valid && in_ready)
        routes.predict_reply(mode, address, mask, next_hop, interface_id, cost);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_op(iprt_pkg::mode_t md, addr_t a, addr_t m, addr_t nh, ifc_t ifc,
                         cost_t c);
    while (gaps_on && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= md;
    address <= a;
    mask <= m;
    next_hop <= nh;
    interface_id <= ifc;
    cost <= c;
    do @(posedge clk); while (!in_ready);
  endtask

  // one edge first so the last accepted transaction is already noted
  task automatic drain_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (routes.expected_replies.size() != 0) @(posedge clk);
  endtask

  initial begin
    int    s;
    int    pick;
    int    plen;
    iprt_pkg::mode_t md;
    addr_t a;
    addr_t m;
    addr_t nh;
    ifc_t  ifc;
    cost_t c;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty table, reserved mode
    send_op(iprt_pkg::MODE_LOOKUP_ANY, 32'h0000_0000, '0, '0, '0, '0);
    send_op(iprt_pkg::MODE_LOOKUP_IFC, 32'hFFFF_FFFF, '1, '1, 8'hFF, '1);
    send_op(MODE_RESERVED, '1, '1, '1, '1, '1);
    // default route, first match with a zero mask
    send_op(iprt_pkg::MODE_UPSERT, 32'h0000_0000, 32'h0000_0000, 32'h0A00_0001, 8'h00,
            16'hFFFF);
    send_op(iprt_pkg::MODE_LOOKUP_ANY, 32'hC0A8_0101, '0, '0, '0, '0);
    // nested prefixes, cost tie-break, equal cost keeps the lower slot
    send_op(iprt_pkg::MODE_UPSERT, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE, 8'h01,
            16'd10);
    send_op(iprt_pkg::MODE_UPSERT, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0001, 8'h02,
            16'd20);
    send_op(iprt_pkg::MODE_UPSERT, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0002, 8'h03,
            16'd5);
    send_op(iprt_pkg::MODE_UPSERT, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0003, 8'h04,
            16'd5);
    send_op(iprt_pkg::MODE_LOOKUP_ANY, 32'h0A01_0203, '0, '0, '0, '0);
    send_op(iprt_pkg::MODE_LOOKUP_IFC, 32'h0A01_0203, '0, '0, 8'h02, '0);
    send_op(iprt_pkg::MODE_LOOKUP_IFC, 32'h0A01_0203, '0, '0, 8'h01, '0);
    send_op(iprt_pkg::MODE_LOOKUP_IFC, 32'h0A01_0203, '0, '0, 8'h07, '0);
    // update in place, then the cheaper route takes over
    send_op(iprt_pkg::MODE_UPSERT, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_00AA, 8'h02,
            16'd0);
    send_op(iprt_pkg::MODE_LOOKUP_ANY, 32'h0A01_0203, '0, '0, '0, '0);
    // host route at all-ones
    send_op(iprt_pkg::MODE_UPSERT, '1, '1, '1, 8'hFF, 16'hFFFF);
    send_op(iprt_pkg::MODE_LOOKUP_ANY, '1, '0, '0, '0, '0);
    send_op(iprt_pkg::MODE_LOOKUP_IFC, 32'h0B00_0000, '0, '0, 8'h00, '0);
    // non-contiguous mask with destination bits outside the mask
    send_op(iprt_pkg::MODE_UPSERT, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 8'h80,
            16'h8000);
    send_op(iprt_pkg::MODE_LOOKUP_ANY, 32'h0000_0000, '0, '0, '0, '0);
    send_op(iprt_pkg::MODE_LOOKUP_IFC, 32'h1010_1010, '0, '0, 8'h80, '0);

    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n == 100 || n == 420) drain_replies();
      gaps_on = !(n >= 200 && n < 350);

      pick = $urandom_range(0, 99);
      if (pick < 4) md = MODE_RESERVED;
      else if (pick < 40) md = iprt_pkg::MODE_UPSERT;
      else if (pick < 72) md = iprt_pkg::MODE_LOOKUP_ANY;
      else md = iprt_pkg::MODE_LOOKUP_IFC;

      a = $urandom;
      m = $urandom;
      nh = $urandom;
      ifc = ($urandom_range(0, 99) < 70) ? ifc_t'($urandom_range(0, 3)) : ifc_t'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 50) c = cost_t'($urandom_range(0, 3));
      else if (pick < 60) c = '1;
      else c = cost_t'($urandom);
      s = routes.pick_slot();

      if (md == iprt_pkg::MODE_UPSERT) begin
        if (s >= 0 && $urandom_range(0, 99) < 55) begin
          // same key: rewrites gateway and cost
          a = routes.ent_dest[s];
          m = routes.ent_mask[s];
          ifc = routes.ent_ifc[s];
        end else begin
          if ($urandom_range(0, 99) < 80) begin
            plen = ($urandom_range(0, 1) == 0) ? 8 * $urandom_range(0, 4)
                                               : $urandom_range(0, 32);
            m = (plen == 0) ? '0 : ('1 << (32 - plen));
          end
          pick = $urandom_range(0, 3);
          if (pick == 0) a[31:16] = 16'h0A01;
          else if (pick == 1) a[31:16] = 16'h0A00;
          else if (pick == 2) a[31:16] = 16'hC0A8;
          if ($urandom_range(0, 99) < 70) a = a & m;
        end
      end else if ((md == iprt_pkg::MODE_LOOKUP_ANY || md == iprt_pkg::MODE_LOOKUP_IFC) &&
                   s >= 0 && $urandom_range(0, 99) < 75) begin
        a = (routes.ent_dest[s] & routes.ent_mask[s]) | (a & ~routes.ent_mask[s]);
        if ($urandom_range(0, 99) < 70) ifc = routes.ent_ifc[s];
      end else if (md != MODE_RESERVED && $urandom_range(0, 1) == 1) begin
        a[31:16] = ($urandom_range(0, 1) == 1) ? 16'h0A01 : 16'hC0A8;
      end
      send_op(md, a, m, nh, ifc, c);
    end

    gaps_on = 1'b1;
    drain_replies();
    repeat (TABLE_ENTRIES + 8) @(posedge clk);
    if (routes.mismatches == 0 && routes.expected_replies.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
